FILE: rtl/core/esc_pkg.sv
// Shared constants, codes and helpers for the sensor compensation block.
`default_nettype none
package esc_pkg;
   localparam int RawW    = 24;
   localparam int HumRawW = 16;
   localparam int CsrIdxW = 3;
   localparam int CsrW    = 64;
   localparam int TempW   = 32;
   localparam int PressW  = 24;
   localparam int HumW    = 17;

   localparam logic [RawW-1:0]    RawOff = 24'h800000;
   localparam logic [HumRawW-1:0] HumOff = 16'h8000;

   // register indexes
   localparam logic [CsrIdxW-1:0] CSR_CAL_TEMP        = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_CAL_PRESS_LOW   = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_CAL_PRESS_HIGH  = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_CAL_PRESS_NINTH = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_CAL_HUM         = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_TEMP_OFFSET     = 3'd5;

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ISSUE = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_WB    = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_DFIN  = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   // program steps, one multiply each
   localparam logic [4:0] PC_T_A     = 5'd0;
   localparam logic [4:0] PC_T_B     = 5'd1;
   localparam logic [4:0] PC_T_FINE  = 5'd2;
   localparam logic [4:0] PC_P_SQ    = 5'd3;
   localparam logic [4:0] PC_P_V2A   = 5'd4;
   localparam logic [4:0] PC_P_V2B   = 5'd5;
   localparam logic [4:0] PC_P_V1A   = 5'd6;
   localparam logic [4:0] PC_P_V1B   = 5'd7;
   localparam logic [4:0] PC_P_V1C   = 5'd8;
   localparam logic [4:0] PC_P_NUM   = 5'd9;
   localparam logic [4:0] PC_P_Q2    = 5'd10;
   localparam logic [4:0] PC_P_Q9    = 5'd11;
   localparam logic [4:0] PC_P_FIN   = 5'd12;
   localparam logic [4:0] PC_H_T     = 5'd13;
   localparam logic [4:0] PC_H_U1    = 5'd14;
   localparam logic [4:0] PC_H_U2    = 5'd15;
   localparam logic [4:0] PC_H_U3    = 5'd16;
   localparam logic [4:0] PC_H_U4    = 5'd17;
   localparam logic [4:0] PC_H_V     = 5'd18;
   localparam logic [4:0] PC_H_W     = 5'd19;
   localparam logic [4:0] PC_H_FIN   = 5'd20;

   localparam logic [3:0] MulLast = 4'hF;   // 16 radix-16 digits
   localparam logic [5:0] DivLast = 6'd63;  // 64 quotient bits

   localparam logic [31:0] HumMax = 32'd419430400;

   function automatic logic [63:0] sx16(input logic [15:0] v);
      sx16 = {{48{v[15]}}, v};
   endfunction

   function automatic logic [63:0] sx32(input logic [31:0] v);
      sx32 = {{32{v[31]}}, v};
   endfunction

   function automatic logic [31:0] asr32(input logic [31:0] v, input int n);
      asr32 = 32'($signed(v) >>> n);
   endfunction

   function automatic logic [63:0] asr64(input logic [63:0] v, input int n);
      asr64 = 64'($signed(v) >>> n);
   endfunction
endpackage
`default_nettype wire

FILE: rtl/core/esc_if.sv
// Channel interfaces: sample request, result response, register write.
`default_nettype none
interface esc_req_if;
   logic                         valid;
   logic                         ready;
   logic [esc_pkg::RawW-1:0]     raw_temp;
   logic [esc_pkg::RawW-1:0]     raw_press;
   logic [esc_pkg::HumRawW-1:0]  raw_hum;
   modport source (output valid, raw_temp, raw_press, raw_hum, input ready);
   modport sink   (input valid, raw_temp, raw_press, raw_hum, output ready);
endinterface

interface esc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [esc_pkg::TempW-1:0]  temp_centi;
   logic                              temp_ok;
   logic [esc_pkg::PressW-1:0]        press_pa;
   logic                              press_ok;
   logic [esc_pkg::HumW-1:0]          hum_q10;
   logic                              hum_ok;
   modport source (output valid, temp_centi, temp_ok, press_pa, press_ok, hum_q10, hum_ok,
                   input ready);
   modport sink   (input valid, temp_centi, temp_ok, press_pa, press_ok, hum_q10, hum_ok,
                   output ready);
endinterface

interface esc_csr_if;
   logic                         valid;
   logic                         ready;
   logic [esc_pkg::CsrIdxW-1:0]  idx;
   logic [esc_pkg::CsrW-1:0]     wdata;
   modport source (output valid, idx, wdata, input ready);
   modport sink   (input valid, idx, wdata, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/environmental_sensor_compensation.sv
// A request runs 21 multiplies (issue, 16 radix-16 digits, writeback each), a 64-bit restoring
// divide with a sign fixup, and an output state before the response transaction.
// A zero pressure divisor skips the divide and four multiplies.
// req_ch.ready is high only while idle, so the block takes no new request while one is in flight,
// and a result waits in the output register until taken.
// Reset (synchronous, active high) clears sequencer, calibration and fine temperature to zero.
`default_nettype none
module environmental_sensor_compensation (
   input  wire logic clock,
   input  wire logic reset,
   esc_req_if.sink   req_ch,
   esc_rsp_if.source rsp_ch,
   esc_csr_if.sink   csr_ch
);
   import esc_pkg::*;

   // calibration registers
   logic [47:0] cal_temp_ff;
   logic [63:0] cal_press_low_ff, cal_press_high_ff, cal_hum_ff;
   logic [15:0] cal_press_ninth_ff;
   logic [23:0] temp_offset_ff;

   // sequencer
   logic [2:0] state_ff, state_in;
   logic [4:0] pc_ff, pc_in;
   logic [5:0] cnt_ff, cnt_in;

   // latched sample
   logic [RawW-1:0]    raw_temp_ff, raw_press_ff;
   logic [HumRawW-1:0] raw_hum_ff;

   // persistent fine temperature
   logic [31:0] fine_ff, fine_in;

   // shared multiplier: a shifts up, b shifts down one hex digit per cycle
   logic [63:0] mul_a_ff, mul_a_in, mul_b_ff, mul_b_in, acc_ff, acc_in;
   logic [63:0] op_a, op_b;

   // divider
   logic [63:0] quo_ff, quo_in, rem_ff, rem_in, dvs_ff, dvs_in;
   logic        neg_ff, neg_in;
   logic [64:0] rem_sh, diff;

   // scratch registers
   logic [63:0] ra_ff, ra_in, rb_ff, rb_in, rc_ff, rc_in, rd_ff, rd_in;

   // result registers
   logic [31:0] temp_ff, temp_in;
   logic [23:0] press_ff, press_in;
   logic [16:0] hum_ff, hum_in;
   logic        temp_ok_ff, temp_ok_in, press_ok_ff, press_ok_in, hum_ok_ff, hum_ok_in;

   // operand views
   logic [19:0] adc_t, adc_p;
   logic [15:0] t1;
   logic [31:0] a32, b32, p32, fine_new, hx, hv, ht;
   logic [63:0] prod, pv1, f64, tmp64, psum, pfin, num;
   logic [11:0] h4, h5;
   logic        t_en, p_en, h_en;

   assign prod  = acc_ff;
   assign p32   = acc_ff[31:0];
   assign adc_t = raw_temp_ff[23:4];
   assign adc_p = raw_press_ff[23:4];
   assign t1    = cal_temp_ff[15:0];
   assign a32   = {15'b0, adc_t[19:3]} - {15'b0, t1, 1'b0};
   assign b32   = {16'b0, adc_t[19:4]} - {16'b0, t1};
   assign pv1   = sx32(fine_ff) - 64'd128000;
   assign hx    = fine_ff - 32'd76800;
   assign h4    = cal_hum_ff[43:32];
   assign h5    = cal_hum_ff[55:44];
   assign t_en  = raw_temp_ff != RawOff;
   assign p_en  = raw_press_ff != RawOff;
   assign h_en  = raw_hum_ff != HumOff;

   assign req_ch.ready = state_ff == ST_IDLE;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid      = state_ff == ST_OUT;
   assign rsp_ch.temp_centi = temp_ff;
   assign rsp_ch.temp_ok    = temp_ok_ff;
   assign rsp_ch.press_pa   = press_ff;
   assign rsp_ch.press_ok   = press_ok_ff;
   assign rsp_ch.hum_q10    = hum_ff;
   assign rsp_ch.hum_ok     = hum_ok_ff;

   // operand selection per program step; 32-bit steps only use the low half
   always_comb begin
      unique case (pc_ff)
         PC_T_A:    begin op_a = sx32(a32);   op_b = sx16(cal_temp_ff[31:16]); end
         PC_T_B:    begin op_a = sx32(b32);   op_b = sx32(b32); end
         PC_T_FINE: begin op_a = rb_ff;       op_b = sx16(cal_temp_ff[47:32]); end
         PC_P_SQ:   begin op_a = pv1;         op_b = pv1; end
         PC_P_V2A:  begin op_a = ra_ff;       op_b = sx16(cal_press_high_ff[31:16]); end
         PC_P_V2B:  begin op_a = pv1;         op_b = sx16(cal_press_high_ff[15:0]); end
         PC_P_V1A:  begin op_a = ra_ff;       op_b = sx16(cal_press_low_ff[47:32]); end
         PC_P_V1B:  begin op_a = pv1;         op_b = sx16(cal_press_low_ff[31:16]); end
         PC_P_V1C:  begin
            op_a = 64'h0000_8000_0000_0000 + rc_ff;
            op_b = {48'b0, cal_press_low_ff[15:0]};
         end
         PC_P_NUM:  begin op_a = num;         op_b = 64'd3125; end
         PC_P_Q2:   begin op_a = asr64(rd_ff, 13); op_b = asr64(rd_ff, 13); end
         PC_P_Q9:   begin op_a = ra_ff;       op_b = sx16(cal_press_ninth_ff); end
         PC_P_FIN:  begin op_a = rd_ff;       op_b = sx16(cal_press_high_ff[63:48]); end
         PC_H_T:    begin op_a = {{52{h5[11]}}, h5}; op_b = sx32(hx); end
         PC_H_U1:   begin op_a = sx32(hx);    op_b = {{56{cal_hum_ff[63]}}, cal_hum_ff[63:56]}; end
         PC_H_U2:   begin op_a = sx32(hx);    op_b = {56'b0, cal_hum_ff[31:24]}; end
         PC_H_U3:   begin op_a = rb_ff;       op_b = rc_ff; end
         PC_H_U4:   begin op_a = rb_ff;       op_b = sx16(cal_hum_ff[23:8]); end
         PC_H_V:    begin op_a = ra_ff;       op_b = rb_ff; end
         PC_H_W:    begin
            op_a = sx32(asr32(ra_ff[31:0], 15));
            op_b = sx32(asr32(ra_ff[31:0], 15));
         end
         PC_H_FIN:  begin op_a = rb_ff;       op_b = {56'b0, cal_hum_ff[7:0]}; end
         default:   begin op_a = '0;          op_b = '0; end
      endcase
   end

   // glue terms used at writeback
   assign fine_new = ra_ff[31:0] + asr32(p32, 14) + {{8{temp_offset_ff[23]}}, temp_offset_ff};
   assign f64      = sx32(fine_new);
   assign tmp64    = asr64((f64 << 2) + f64 + 64'd128, 8);
   // rb_ff holds var2 of the pressure formula here
   assign num      = ((64'd1048576 - {44'b0, adc_p}) << 31) - rb_ff;
   assign psum     = rd_ff + ra_ff + asr64(prod, 19);
   assign pfin     = asr64(psum, 8) + (sx16(cal_press_high_ff[47:32]) << 4);
   assign ht       = {2'b0, raw_hum_ff, 14'b0} - {h4, 20'b0} - p32;
   assign hv       = ra_ff[31:0] - asr32(p32, 4);
   assign rem_sh   = {rem_ff, quo_ff[63]};
   assign diff     = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      state_in    = state_ff;
      pc_in       = pc_ff;
      cnt_in      = cnt_ff;
      fine_in     = fine_ff;
      mul_a_in    = mul_a_ff;
      mul_b_in    = mul_b_ff;
      acc_in      = acc_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      dvs_in      = dvs_ff;
      neg_in      = neg_ff;
      ra_in       = ra_ff;
      rb_in       = rb_ff;
      rc_in       = rc_ff;
      rd_in       = rd_ff;
      temp_in     = temp_ff;
      press_in    = press_ff;
      hum_in      = hum_ff;
      temp_ok_in  = temp_ok_ff;
      press_ok_in = press_ok_ff;
      hum_ok_in   = hum_ok_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               state_in    = ST_ISSUE;
               pc_in       = PC_T_A;
               temp_in     = '0;
               press_in    = '0;
               hum_in      = '0;
               temp_ok_in  = 1'b0;
               press_ok_in = 1'b0;
               hum_ok_in   = 1'b0;
            end
         end
         ST_ISSUE: begin
            mul_a_in = op_a;
            mul_b_in = op_b;
            acc_in   = '0;
            cnt_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            acc_in   = acc_ff + 64'(mul_a_ff * mul_b_ff[3:0]);
            mul_a_in = mul_a_ff << 4;
            mul_b_in = mul_b_ff >> 4;
            cnt_in   = cnt_ff + 6'd1;
            if (cnt_ff[3:0] == MulLast) state_in = ST_WB;
         end
         ST_WB: begin
            pc_in    = pc_ff + 5'd1;
            state_in = ST_ISSUE;
            unique case (pc_ff)
               PC_T_A:    ra_in = {32'b0, asr32(p32, 11)};
               PC_T_B:    rb_in = {32'b0, asr32(p32, 12)};
               PC_T_FINE: begin
                  // disabled temperature keeps the old fine value
                  if (t_en) begin
                     fine_in    = fine_new;
                     temp_in    = tmp64[31:0];
                     temp_ok_in = 1'b1;
                  end
               end
               PC_P_SQ:   ra_in = prod;
               PC_P_V2A:  rb_in = prod;
               PC_P_V2B:  rb_in = rb_ff + (prod << 17) + (sx16(cal_press_low_ff[63:48]) << 35);
               PC_P_V1A:  rc_in = asr64(prod, 8);
               PC_P_V1B:  rc_in = rc_ff + (prod << 12);
               PC_P_V1C:  begin
                  rc_in = asr64(prod, 33);
                  // zero divisor: pressure invalid, go straight to humidity
                  if (asr64(prod, 33) == 64'd0) pc_in = PC_H_T;
               end
               PC_P_NUM:  begin
                  quo_in   = prod[63] ? -prod : prod;
                  dvs_in   = rc_ff[63] ? -rc_ff : rc_ff;
                  neg_in   = prod[63] ^ rc_ff[63];
                  rem_in   = '0;
                  cnt_in   = '0;
                  state_in = ST_DIV;
               end
               PC_P_Q2:   ra_in = prod;
               PC_P_Q9:   ra_in = asr64(prod, 25);
               PC_P_FIN:  begin
                  if (p_en) begin
                     press_in    = pfin[31:8];
                     press_ok_in = 1'b1;
                  end
               end
               PC_H_T:    ra_in = {32'b0, asr32(ht + 32'd16384, 15)};
               PC_H_U1:   rb_in = {32'b0, asr32(p32, 10)};
               PC_H_U2:   rc_in = {32'b0, asr32(p32, 11) + 32'd32768};
               PC_H_U3:   rb_in = {32'b0, asr32(p32, 10) + 32'd2097152};
               PC_H_U4:   rb_in = {32'b0, asr32(p32 + 32'd8192, 14)};
               PC_H_V:    ra_in = {32'b0, p32};
               PC_H_W:    rb_in = {32'b0, asr32(p32, 7)};
               PC_H_FIN:  begin
                  state_in = ST_OUT;
                  if (h_en) begin
                     hum_ok_in = 1'b1;
                     priority if (hv[31])      hum_in = '0;
                     else if (hv > HumMax)     hum_in = HumMax[28:12];
                     else                      hum_in = hv[28:12];
                  end
               end
               default: state_in = ST_OUT;
            endcase
         end
         ST_DIV: begin
            // restoring divide on magnitudes, one quotient bit per cycle
            if (!diff[64]) begin
               rem_in = diff[63:0];
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = rem_sh[63:0];
               quo_in = {quo_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == DivLast) state_in = ST_DFIN;
         end
         ST_DFIN: begin
            rd_in    = neg_ff ? -quo_ff : quo_ff;
            pc_in    = PC_P_Q2;
            state_in = ST_ISSUE;
         end
         ST_OUT: begin
            if (rsp_ch.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         pc_ff              <= PC_T_A;
         cnt_ff             <= '0;
         fine_ff            <= '0;
         cal_temp_ff        <= '0;
         cal_press_low_ff   <= '0;
         cal_press_high_ff  <= '0;
         cal_press_ninth_ff <= '0;
         cal_hum_ff         <= '0;
         temp_offset_ff     <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         cnt_ff   <= cnt_in;
         fine_ff  <= fine_in;
         if (csr_ch.valid) begin
            unique case (csr_ch.idx)
               CSR_CAL_TEMP:        cal_temp_ff        <= csr_ch.wdata[47:0];
               CSR_CAL_PRESS_LOW:   cal_press_low_ff   <= csr_ch.wdata;
               CSR_CAL_PRESS_HIGH:  cal_press_high_ff  <= csr_ch.wdata;
               CSR_CAL_PRESS_NINTH: cal_press_ninth_ff <= csr_ch.wdata[15:0];
               CSR_CAL_HUM:         cal_hum_ff         <= csr_ch.wdata;
               CSR_TEMP_OFFSET:     temp_offset_ff     <= csr_ch.wdata[23:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         raw_temp_ff  <= req_ch.raw_temp;
         raw_press_ff <= req_ch.raw_press;
         raw_hum_ff   <= req_ch.raw_hum;
      end
      mul_a_ff    <= mul_a_in;
      mul_b_ff    <= mul_b_in;
      acc_ff      <= acc_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      neg_ff      <= neg_in;
      ra_ff       <= ra_in;
      rb_ff       <= rb_in;
      rc_ff       <= rc_in;
      rd_ff       <= rd_in;
      temp_ff     <= temp_in;
      press_ff    <= press_in;
      hum_ff      <= hum_in;
      temp_ok_ff  <= temp_ok_in;
      press_ok_ff <= press_ok_in;
      hum_ok_ff   <= hum_ok_in;
   end

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("request taken while result pending");
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> state_ff == ST_ISSUE && pc_ff == PC_T_A)
      else $error("sequencer did not start");
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> dvs_ff != 64'd0)
      else $error("divide by zero");
   a_rsp_done: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ready |=> state_ff == ST_IDLE)
      else $error("no return to idle after result");
`endif
endmodule
`default_nettype wire

FILE: bench/esc_tb_if.sv
// Testbench-side note: channel interfaces come from the RTL's esc_if.sv; this file holds shared bench types.
package esc_tb_pkg;
   typedef struct packed {
      logic [23:0] raw_temp;
      logic [23:0] raw_press;
      logic [15:0] raw_hum;
   } sample_type;

   typedef struct packed {
      logic [31:0] temp_centi;
      logic        temp_ok;
      logic [23:0] press_pa;
      logic        press_ok;
      logic [16:0] hum_q10;
      logic        hum_ok;
   } reading_type;
endpackage

FILE: bench/esc_checker.sv
// Checker: mirrors the compensation math, compares every response transaction.
module esc_checker (
   input  wire logic clock,
   input  wire logic reset,
   esc_req_if.sink   req_mon,
   esc_rsp_if.sink   rsp_mon,
   esc_csr_if.sink   csr_mon,
   output int        fail_count,
   output int        pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import esc_pkg::*;
   import esc_tb_pkg::*;

   logic [47:0] k_temp;
   logic [63:0] k_plo, k_phi, k_hum;
   logic [15:0] k_p9;
   logic [23:0] k_off;
   logic [31:0] fine_q;
   reading_type readings_due[$];

   function automatic logic [63:0] sdiv(logic [63:0] a, logic [63:0] b);
      logic [63:0] ma, mb, q;
      ma = a[63] ? -a : a;
      mb = b[63] ? -b : b;
      q = ma / mb;
      return (a[63] != b[63]) ? -q : q;
   endfunction

   function automatic logic [31:0] sr32(logic [31:0] v, int n);
      return $signed(v) >>> n;
   endfunction

   function automatic logic [63:0] sr64(logic [63:0] v, int n);
      return $signed(v) >>> n;
   endfunction

   // compensates one sample, updating the held fine temperature
   function automatic reading_type compensate(sample_type s);
      reading_type r;
      logic [31:0] adc, t1, t2, t3, a, b, v1t, v2t;
      logic [63:0] f, p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p;
      logic [31:0] h1, h2, h3, h4, h5, h6, x, t, u, v;
      r = '0;
      if (s.raw_temp != RawOff) begin
         adc = {8'd0, s.raw_temp} >> 4;
         t1 = {16'd0, k_temp[15:0]};
         t2 = {{16{k_temp[31]}}, k_temp[31:16]};
         t3 = {{16{k_temp[47]}}, k_temp[47:32]};
         a = (adc >> 3) - (t1 << 1);
         v1t = sr32(a * t2, 11);
         b = (adc >> 4) - t1;
         v2t = sr32(sr32(b * b, 12) * t3, 14);
         fine_q = v1t + v2t + {{8{k_off[23]}}, k_off};
         f = {{32{fine_q[31]}}, fine_q};
         r.temp_centi = 32'(sr64(f * 5 + 128, 8));
         r.temp_ok = 1'b1;
      end
      if (s.raw_press != RawOff) begin
         p1 = {48'd0, k_plo[15:0]};
         p2 = {{48{k_plo[31]}}, k_plo[31:16]};
         p3 = {{48{k_plo[47]}}, k_plo[47:32]};
         p4 = {{48{k_plo[63]}}, k_plo[63:48]};
         p5 = {{48{k_phi[15]}}, k_phi[15:0]};
         p6 = {{48{k_phi[31]}}, k_phi[31:16]};
         p7 = {{48{k_phi[47]}}, k_phi[47:32]};
         p8 = {{48{k_phi[63]}}, k_phi[63:48]};
         p9 = {{48{k_p9[15]}}, k_p9};
         v1 = {{32{fine_q[31]}}, fine_q} - 64'd128000;
         v2 = v1 * v1 * p6;
         v2 += (v1 * p5) << 17;
         v2 += p4 << 35;
         v1 = sr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
         v1 = sr64(((64'd1 << 47) + v1) * p1, 33);
         if (v1 != 0) begin
            p = 64'd1048576 - ({40'd0, s.raw_press} >> 4);
            p = sdiv(((p << 31) - v2) * 64'd3125, v1);
            v1 = sr64(p9 * sr64(p, 13) * sr64(p, 13), 25);
            v2 = sr64(p8 * p, 19);
            p = sr64(p + v1 + v2, 8) + (p7 << 4);
            r.press_pa = p[31:8];
            r.press_ok = 1'b1;
         end
      end
      if (s.raw_hum != HumOff) begin
         h1 = {24'd0, k_hum[7:0]};
         h2 = {{16{k_hum[23]}}, k_hum[23:8]};
         h3 = {24'd0, k_hum[31:24]};
         h4 = {{20{k_hum[43]}}, k_hum[43:32]};
         h5 = {{20{k_hum[55]}}, k_hum[55:44]};
         h6 = {{24{k_hum[63]}}, k_hum[63:56]};
         x = fine_q - 32'd76800;
         t = ({16'd0, s.raw_hum} << 14) - (h4 << 20) - h5 * x;
         t = sr32(t + 32'd16384, 15);
         u = sr32(x * h6, 10) * (sr32(x * h3, 11) + 32'd32768);
         u = sr32(u, 10) + 32'd2097152;
         u = sr32(u * h2 + 32'd8192, 14);
         v = t * u;
         v = v - sr32(sr32(sr32(v, 15) * sr32(v, 15), 7) * h1, 4);
         if (v[31]) v = 0;
         else if (v > HumMax) v = HumMax;
         r.hum_q10 = v[28:12];
         r.hum_ok = 1'b1;
      end
      return r;
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      reading_type want;
      sample_type  s;
      if (reset) begin
         k_temp <= '0; k_plo <= '0; k_phi <= '0; k_p9 <= '0; k_hum <= '0; k_off <= '0;
         fine_q = '0;
         fail_count = 0;
         readings_due.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.idx)
               CSR_CAL_TEMP:        k_temp <= csr_mon.wdata[47:0];
               CSR_CAL_PRESS_LOW:   k_plo  <= csr_mon.wdata;
               CSR_CAL_PRESS_HIGH:  k_phi  <= csr_mon.wdata;
               CSR_CAL_PRESS_NINTH: k_p9   <= csr_mon.wdata[15:0];
               CSR_CAL_HUM:         k_hum  <= csr_mon.wdata;
               CSR_TEMP_OFFSET:     k_off  <= csr_mon.wdata[23:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            s = {req_mon.raw_temp, req_mon.raw_press, req_mon.raw_hum};
            readings_due.push_back(compensate(s));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (readings_due.size() == 0) begin
               report("unexpected transaction", 0, 0);
            end else begin
               want = readings_due.pop_front();
               if (rsp_mon.temp_centi !== want.temp_centi)
                  report("temp_centi", rsp_mon.temp_centi, want.temp_centi);
               if (rsp_mon.temp_ok !== want.temp_ok)
                  report("temp_ok", rsp_mon.temp_ok, want.temp_ok);
               if (rsp_mon.press_pa !== want.press_pa)
                  report("press_pa", rsp_mon.press_pa, want.press_pa);
               if (rsp_mon.press_ok !== want.press_ok)
                  report("press_ok", rsp_mon.press_ok, want.press_ok);
               if (rsp_mon.hum_q10 !== want.hum_q10)
                  report("hum_q10", rsp_mon.hum_q10, want.hum_q10);
               if (rsp_mon.hum_ok !== want.hum_ok)
                  report("hum_ok", rsp_mon.hum_ok, want.hum_ok);
            end
         end
      end
      pending = readings_due.size();
   end
endmodule

FILE: bench/environmental_sensor_compensation_tb.sv
// Top: clock, reset, stimulus phases across calibration sets, and the verdict.
module environmental_sensor_compensation_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import esc_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending;
   int   stall_cnt;
   int   idle_cycles;

   esc_req_if req_ch();
   esc_rsp_if rsp_ch();
   esc_csr_if csr_ch();

   environmental_sensor_compensation u_top (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch)
   );

   esc_checker u_chk (
      .clock(clock), .reset(reset), .req_mon(req_ch), .rsp_mon(rsp_ch), .csr_mon(csr_ch),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: ends the run as a mismatch when the idle counter reaches StallLimit; any handshake restarts it.
   localparam int StallLimit = 20000;
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Response side: random back-pressure after each transaction, with always-ready
   // stretches in the eager phases.
   bit sink_eager = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_cnt <= 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         stall_cnt <= sink_eager ? 0 : $urandom_range(0, 13);
         rsp_ch.ready <= sink_eager;
      end else if (stall_cnt > 0) begin
         stall_cnt <= stall_cnt - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // valid drops for one cycle after each write
   task automatic csr_write(logic [CsrIdxW-1:0] idx, logic [63:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.idx   <= idx;
      csr_ch.wdata <= data;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Drain: every expected transaction back, then let the block settle.
   task automatic drain();
      while (pending != 0) @(posedge clock);
      repeat (500) @(posedge clock);
   endtask

   // valid drops after each transaction, for a random gap unless eager; the block is busy then anyway
   task automatic send(logic [23:0] t, logic [23:0] p, logic [15:0] h, bit eager);
      if (!eager) repeat ($urandom_range(0, 13)) @(posedge clock);
      req_ch.valid     <= 1'b1;
      req_ch.raw_temp  <= t;
      req_ch.raw_press <= p;
      req_ch.raw_hum   <= h;
      do @(posedge clock); while (!req_ch.ready);
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly realistic readings near the nominal ADC range, with the disabled
   // markers and full-range noise mixed in.
   function automatic logic [23:0] pick_raw24();
      case ($urandom_range(0, 9))
         0:       return RawOff;
         1, 2:    return 24'($urandom);
         3:       return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
         default: return 24'($urandom_range(24'h500000, 24'h900000));
      endcase
   endfunction

   function automatic logic [15:0] pick_raw16();
      case ($urandom_range(0, 9))
         0:       return HumOff;
         1, 2:    return 16'($urandom);
         default: return 16'($urandom_range(16'h4000, 16'h9000));
      endcase
   endfunction

   // Typical calibration, randomly jittered so each phase differs.
   task automatic load_typical();
      logic [15:0] t1, t2, t3;
      t1 = 16'd27504 + 16'($urandom_range(0, 2000));
      t2 = 16'd26435 - 16'($urandom_range(0, 2000));
      t3 = 16'($signed(-16'sd1000) + $signed(16'($urandom_range(0, 2000))));
      csr_write(CSR_CAL_TEMP, {16'd0, t3, t2, t1});
      csr_write(CSR_CAL_PRESS_LOW, {16'd2855, 16'd3024, 16'hD6E0 ^ 16'($urandom_range(0, 255)),
                                    16'd36477 + 16'($urandom_range(0, 1000))});
      csr_write(CSR_CAL_PRESS_HIGH, {16'hEA6D, 16'd15500, 16'hFFF9, 16'd140});
      csr_write(CSR_CAL_PRESS_NINTH, 64'(16'd6000 + 16'($urandom_range(0, 200))));
      csr_write(CSR_CAL_HUM, {8'd30, 12'd50, 12'd312, 8'd0, 16'd362, 8'd75});
      csr_write(CSR_TEMP_OFFSET, 64'($urandom_range(0, 2000)) - 64'd1000);
   endtask

   initial begin
      req_ch.valid = 1'b0; req_ch.raw_temp = '0; req_ch.raw_press = '0; req_ch.raw_hum = '0;
      csr_ch.valid = 1'b0; csr_ch.idx = '0; csr_ch.wdata = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset calibration: all zero, so the pressure divisor is zero.
      send(24'h123450, 24'h654320, 16'h6000, 1'b0);
      send(RawOff, RawOff, HumOff, 1'b0);
      drain();

      // Directed: typical set, field extremes and disabled channels.
      load_typical();
      send(24'h000000, 24'h000000, 16'h0000, 1'b0);
      send(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 1'b0);
      send(24'h7FFFFF, 24'h800001, 16'h7FFF, 1'b0);
      send(RawOff, 24'h600000, 16'h6000, 1'b0);   // temp off: old fine value reused
      send(24'h800010, RawOff, HumOff, 1'b0);
      send(24'h7FFFF0, 24'h000010, 16'h8001, 1'b0);
      send(24'h820000, 24'h520000, 16'h9000, 1'b1);
      send(24'h500000, 24'h800000, 16'hFFFF, 1'b1);
      drain();   // sender holds off until every result is back

      // Extreme calibration values.
      csr_write(CSR_CAL_TEMP, 64'hFFFF_FFFF_FFFF);
      csr_write(CSR_CAL_PRESS_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(CSR_CAL_PRESS_HIGH, 64'h8000_7FFF_8000_7FFF);
      csr_write(CSR_CAL_PRESS_NINTH, 64'h8000);
      csr_write(CSR_CAL_HUM, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(CSR_TEMP_OFFSET, 64'h7FFFFF);
      send(24'hFFFFFF, 24'h000000, 16'hFFFF, 1'b0);
      send(24'h000000, 24'hFFFFFF, 16'h0000, 1'b0);
      send(RawOff, 24'h400000, 16'h1234, 1'b0);
      drain();
      csr_write(CSR_TEMP_OFFSET, 64'h800000);
      csr_write(CSR_CAL_PRESS_NINTH, 64'h7FFF);
      csr_write(CSR_CAL_PRESS_HIGH, 64'h7FFF_8000_7FFF_8000);
      send(24'h000000, 24'h000000, 16'h0000, 1'b0);
      send(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 1'b0);
      drain();

      // Random phases: mostly typical calibrations, some fully random ones.
      for (int ph = 0; ph < 12; ph++) begin
         if (ph % 4 == 3) begin
            for (int r = 0; r < 6; r++)
               csr_write(CsrIdxW'(r), {$urandom, $urandom});
         end else begin
            load_typical();
         end
         sink_eager = (ph % 3 == 1);
         for (int n = 0; n < 150; n++)
            send(pick_raw24(), pick_raw24(), pick_raw16(), sink_eager || (n % 40 < 8));
         drain();
      end

      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

FILE: files.f
rtl/core/esc_pkg.sv
rtl/core/esc_if.sv
rtl/core/environmental_sensor_compensation.sv
bench/esc_tb_if.sv
bench/esc_checker.sv
bench/environmental_sensor_compensation_tb.sv
